// File: design/frame_header_deframer_assert.svh
// ----------------------------------------------------------------------------
// frame header deframer assertion macros
// concurrent checks clocked on aclk and held off while aresetn is low
// ----------------------------------------------------------------------------
`ifndef FRAME_HEADER_DEFRAMER_ASSERT_SVH
`define FRAME_HEADER_DEFRAMER_ASSERT_SVH

// consequence holds in the same cycle as the condition
`define FHD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequence holds in the cycle after the condition
`define FHD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/fhd_pkg.sv
// ----------------------------------------------------------------------------
// fhd_pkg
// shared types, codes and constants of the frame header deframer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fhd_pkg;

    // header geometry
    localparam int HEADER_BYTES = 32;
    localparam int POS_W        = $clog2(HEADER_BYTES);
    localparam logic [POS_W-1:0] LAST_POS     = POS_W'(HEADER_BYTES - 1);
    localparam logic [POS_W-1:0] OFS_VERSION  = POS_W'(4);
    localparam logic [POS_W-1:0] OFS_TYPE     = POS_W'(6);
    localparam logic [POS_W-1:0] OFS_FLAGS    = POS_W'(8);
    localparam logic [POS_W-1:0] OFS_META     = POS_W'(12);
    localparam logic [POS_W-1:0] OFS_PAYLOAD  = POS_W'(16);
    localparam logic [POS_W-1:0] OFS_STREAM   = POS_W'(24);

    // header + payload + metadata needs one carry bit above 64
    localparam int SUM_W      = 65;
    localparam int TYPE_IDX_W = 6;

    // parser phases
    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_BODY   = 2'd1;
    localparam logic [1:0] PH_ERROR  = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_META    = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    // error codes
    localparam logic [2:0] ERR_MAGIC    = 3'd0;
    localparam logic [2:0] ERR_VERSION  = 3'd1;
    localparam logic [2:0] ERR_TYPE     = 3'd2;
    localparam logic [2:0] ERR_META_BIG = 3'd3;
    localparam logic [2:0] ERR_PAY_BIG  = 3'd4;
    localparam logic [2:0] ERR_OVERFLOW = 3'd5;
    localparam logic [2:0] ERR_FRAME_BIG = 3'd6;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE_MASK = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_META  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAY   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME = 3'd5;

    typedef struct packed {
        logic [31:0] magic_word;
        logic [15:0] expected_version;
        logic [63:0] known_type_mask;
        logic [31:0] max_metadata_len;
        logic [63:0] max_payload_len;
        logic [63:0] max_frame_len;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        magic_word:       32'h5244_4654,
        expected_version: 16'd1,
        known_type_mask:  '1,
        max_metadata_len: 32'd65536,
        max_payload_len:  '1,
        max_frame_len:    '1
    };

    // header fields the validity check looks at
    typedef struct packed {
        logic [31:0] magic;
        logic [15:0] version;
        logic [15:0] msg_type;
        logic [31:0] metadata_len;
        logic [63:0] payload_len;
    } hdr_t;

    typedef struct packed {
        logic       bad;
        logic [2:0] code;
    } chk_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  byte_value;
        logic [2:0]  error_code;
        logic [15:0] msg_type;
        logic [31:0] frame_flags;
        logic [31:0] metadata_len;
        logic [63:0] payload_len;
        logic [63:0] stream_ident;
        logic        last;
    } result_t;

endpackage

// File: design/fhd_cfg_regs.sv
// ----------------------------------------------------------------------------
// fhd_cfg_regs
// configuration register file with a one-cycle hold flag after each write
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fhd_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fhd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                   cfg_data,
    output fhd_pkg::cfg_t                 cfg,
    output logic                          cfg_hold
);

    fhd_pkg::cfg_t cfg_reg, cfg_next;
    logic          hold_reg;
    logic          wr_en;

    assign cfg_ready = 1'b1;
    assign wr_en     = cfg_valid && cfg_ready;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (cfg_index)
                fhd_pkg::CFG_MAGIC:     cfg_next.magic_word       = cfg_data[31:0];
                fhd_pkg::CFG_VERSION:   cfg_next.expected_version = cfg_data[15:0];
                fhd_pkg::CFG_TYPE_MASK: cfg_next.known_type_mask  = cfg_data;
                fhd_pkg::CFG_MAX_META:  cfg_next.max_metadata_len = cfg_data[31:0];
                fhd_pkg::CFG_MAX_PAY:   cfg_next.max_payload_len  = cfg_data;
                fhd_pkg::CFG_MAX_FRAME: cfg_next.max_frame_len    = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg  <= fhd_pkg::CFG_RESET;
            hold_reg <= 1'b0;
        end else begin
            cfg_reg  <= cfg_next;
            hold_reg <= wr_en;
        end
    end

    assign cfg      = cfg_reg;
    assign cfg_hold = hold_reg;

endmodule

// File: design/fhd_hdr_check.sv
// ----------------------------------------------------------------------------
// fhd_hdr_check
// two-stage header validation: length sum, then prioritized limit checks
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fhd_hdr_check (
    input  logic          aclk,
    input  fhd_pkg::hdr_t hdr,
    input  fhd_pkg::cfg_t cfg,
    output fhd_pkg::chk_t chk
);

    logic [fhd_pkg::SUM_W-1:0] sum_reg, sum_next;
    fhd_pkg::chk_t             chk_reg, chk_next;
    logic                      type_known;

    assign sum_next = fhd_pkg::SUM_W'(fhd_pkg::HEADER_BYTES)
                    + fhd_pkg::SUM_W'(hdr.payload_len)
                    + fhd_pkg::SUM_W'(hdr.metadata_len);

    // types at or above the mask width are never known
    assign type_known = (hdr.msg_type[15:fhd_pkg::TYPE_IDX_W] == '0)
                     && cfg.known_type_mask[hdr.msg_type[fhd_pkg::TYPE_IDX_W-1:0]];

    always_comb begin
        chk_next.bad  = 1'b1;
        chk_next.code = fhd_pkg::ERR_MAGIC;
        if (hdr.magic != cfg.magic_word) begin
            chk_next.code = fhd_pkg::ERR_MAGIC;
        end else if (hdr.version != cfg.expected_version) begin
            chk_next.code = fhd_pkg::ERR_VERSION;
        end else if (!type_known) begin
            chk_next.code = fhd_pkg::ERR_TYPE;
        end else if (hdr.metadata_len > cfg.max_metadata_len) begin
            chk_next.code = fhd_pkg::ERR_META_BIG;
        end else if (hdr.payload_len > cfg.max_payload_len) begin
            chk_next.code = fhd_pkg::ERR_PAY_BIG;
        end else if (sum_reg[fhd_pkg::SUM_W-1]) begin
            chk_next.code = fhd_pkg::ERR_OVERFLOW;
        end else if (sum_reg[63:0] > cfg.max_frame_len) begin
            chk_next.code = fhd_pkg::ERR_FRAME_BIG;
        end else if (sum_reg[63]) begin
            chk_next.code = fhd_pkg::ERR_OVERFLOW;
        end else begin
            chk_next.bad  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg <= sum_next;
        chk_reg <= chk_next;
    end

    assign chk = chk_reg;

endmodule

// File: design/fhd_out_skid.sv
// ----------------------------------------------------------------------------
// fhd_out_skid
// output register with a skid stage, registered ready toward the parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fhd_out_skid (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  fhd_pkg::result_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output fhd_pkg::result_t out_data
);

    logic             out_valid_reg, skid_valid_reg;
    fhd_pkg::result_t out_data_reg, skid_data_reg;
    logic             out_free;

    assign out_free = out_ready || !out_valid_reg;
    assign in_ready = !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= in_valid;
            end
        end else if (in_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end else if (in_valid) begin
            skid_data_reg <= in_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: design/frame_header_deframer.sv
// a result shows on the m_ channel from the output register, or after it has waited in the skid register
// throughput: one byte per cycle while s_ready is high; a two-entry output register/skid keeps input moving
// s_ready drops for one cycle after each configuration write while the header check reloads
// reset (aresetn low, synchronous): header phase, position zero, output empty, config to defaults
// header field stores are not cleared by reset; each is written before it is read
// ----------------------------------------------------------------------------
// frame_header_deframer
// byte-stream parser for a fixed 32-byte big-endian frame header followed by
// a metadata and payload body, with header validation and sticky error
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "frame_header_deframer_assert.svh"

module frame_header_deframer (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input byte stream
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_data_byte,
    // results
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_kind,
    output logic [7:0]                    m_byte_value,
    output logic [2:0]                    m_error_code,
    output logic [15:0]                   m_msg_type,
    output logic [31:0]                   m_frame_flags,
    output logic [31:0]                   m_metadata_len,
    output logic [63:0]                   m_payload_len,
    output logic [63:0]                   m_stream_ident,
    output logic                          m_last,
    // configuration writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fhd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                   cfg_data
);

    // control state
    logic [1:0]                phase_reg, phase_next;
    logic [fhd_pkg::POS_W-1:0] pos_reg, pos_next;

    // header field stores, also the body down-counters
    logic [31:0] got_magic_reg, got_magic_next;
    logic [15:0] got_version_reg, got_version_next;
    logic [15:0] got_type_reg, got_type_next;
    logic [31:0] got_flags_reg, got_flags_next;
    logic [63:0] got_stream_reg, got_stream_next;
    logic [31:0] meta_left_reg, meta_left_next;
    logic [63:0] payload_left_reg, payload_left_next;

    fhd_pkg::cfg_t    cfg;
    logic             cfg_hold;
    fhd_pkg::hdr_t    hdr;
    fhd_pkg::chk_t    chk;
    fhd_pkg::result_t res, out_res;
    logic             res_valid;
    logic             res_ready;
    logic             s_accept;

    // body end detection without a decrement in the path
    logic meta_one, pay_zero, pay_one;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    fhd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .cfg_hold  (cfg_hold)
    );

    // ------------------------------------------------------------------
    // header check runs ahead continuously; the checked fields are all
    // complete once header byte 23 is in, eight bytes before the last one
    // ------------------------------------------------------------------
    assign hdr.magic        = got_magic_reg;
    assign hdr.version      = got_version_reg;
    assign hdr.msg_type     = got_type_reg;
    assign hdr.metadata_len = meta_left_reg;
    assign hdr.payload_len  = payload_left_reg;

    fhd_hdr_check u_check (
        .aclk (aclk),
        .hdr  (hdr),
        .cfg  (cfg),
        .chk  (chk)
    );

    // input is taken whenever the skid has room, except right after a
    // config write so the check stage sees the new limits
    assign s_ready  = res_ready && !cfg_hold;
    assign s_accept = s_valid && s_ready;

    assign meta_one = (meta_left_reg == 32'd1);
    assign pay_zero = (payload_left_reg == '0);
    assign pay_one  = (payload_left_reg == 64'd1);

    // ------------------------------------------------------------------
    // per-byte parse
    // ------------------------------------------------------------------
    always_comb begin
        phase_next        = phase_reg;
        pos_next          = pos_reg;
        got_magic_next    = got_magic_reg;
        got_version_next  = got_version_reg;
        got_type_next     = got_type_reg;
        got_flags_next    = got_flags_reg;
        got_stream_next   = got_stream_reg;
        meta_left_next    = meta_left_reg;
        payload_left_next = payload_left_reg;
        res_valid         = 1'b0;
        res               = '0;

        if (s_accept) begin
            case (phase_reg)
                fhd_pkg::PH_HEADER: begin
                    // shift the byte into the field that owns this position
                    if (pos_reg < fhd_pkg::OFS_VERSION) begin
                        got_magic_next = {got_magic_reg[23:0], s_data_byte};
                    end else if (pos_reg < fhd_pkg::OFS_TYPE) begin
                        got_version_next = {got_version_reg[7:0], s_data_byte};
                    end else if (pos_reg < fhd_pkg::OFS_FLAGS) begin
                        got_type_next = {got_type_reg[7:0], s_data_byte};
                    end else if (pos_reg < fhd_pkg::OFS_META) begin
                        got_flags_next = {got_flags_reg[23:0], s_data_byte};
                    end else if (pos_reg < fhd_pkg::OFS_PAYLOAD) begin
                        meta_left_next = {meta_left_reg[23:0], s_data_byte};
                    end else if (pos_reg < fhd_pkg::OFS_STREAM) begin
                        payload_left_next = {payload_left_reg[55:0], s_data_byte};
                    end else begin
                        got_stream_next = {got_stream_reg[55:0], s_data_byte};
                    end

                    if (pos_reg == fhd_pkg::LAST_POS) begin
                        pos_next  = '0;
                        res_valid = 1'b1;
                        if (chk.bad) begin
                            // bad header: report once, then drop everything
                            res.kind       = fhd_pkg::KIND_ERROR;
                            res.error_code = chk.code;
                            res.last       = 1'b1;
                            phase_next     = fhd_pkg::PH_ERROR;
                        end else begin
                            res.kind         = fhd_pkg::KIND_HEADER;
                            res.msg_type     = got_type_reg;
                            res.frame_flags  = got_flags_reg;
                            res.metadata_len = meta_left_reg;
                            res.payload_len  = payload_left_reg;
                            res.stream_ident = got_stream_next;
                            // empty body closes the frame on the header record
                            if ((meta_left_reg == '0) && pay_zero) begin
                                res.last   = 1'b1;
                                phase_next = fhd_pkg::PH_HEADER;
                            end else begin
                                phase_next = fhd_pkg::PH_BODY;
                            end
                        end
                    end else begin
                        pos_next = pos_reg + 1'b1;
                    end
                end

                fhd_pkg::PH_BODY: begin
                    res_valid      = 1'b1;
                    res.byte_value = s_data_byte;
                    // metadata bytes come first, then payload bytes
                    if (meta_left_reg != '0) begin
                        res.kind       = fhd_pkg::KIND_META;
                        meta_left_next = meta_left_reg - 1'b1;
                        res.last       = meta_one && pay_zero;
                    end else begin
                        res.kind = fhd_pkg::KIND_PAYLOAD;
                        if (!pay_zero) begin
                            payload_left_next = payload_left_reg - 1'b1;
                        end
                        res.last = pay_one || pay_zero;
                    end
                    if (res.last) begin
                        phase_next = fhd_pkg::PH_HEADER;
                        pos_next   = '0;
                    end
                end

                // error phase and the unused code swallow every byte
                default: ;
            endcase
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= fhd_pkg::PH_HEADER;
            pos_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
        end
    end

    // header stores and counters, written before they are read
    always_ff @(posedge aclk) begin
        got_magic_reg    <= got_magic_next;
        got_version_reg  <= got_version_next;
        got_type_reg     <= got_type_next;
        got_flags_reg    <= got_flags_next;
        got_stream_reg   <= got_stream_next;
        meta_left_reg    <= meta_left_next;
        payload_left_reg <= payload_left_next;
    end

    // ------------------------------------------------------------------
    // result register and skid stage
    // ------------------------------------------------------------------
    fhd_out_skid u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_ready  (res_ready),
        .in_data   (res),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_res)
    );

    assign m_kind         = out_res.kind;
    assign m_byte_value   = out_res.byte_value;
    assign m_error_code   = out_res.error_code;
    assign m_msg_type     = out_res.msg_type;
    assign m_frame_flags  = out_res.frame_flags;
    assign m_metadata_len = out_res.metadata_len;
    assign m_payload_len  = out_res.payload_len;
    assign m_stream_ident = out_res.stream_ident;
    assign m_last         = out_res.last;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `FHD_ASSERT_NEXT(a_cfg_holds_input, cfg_valid && cfg_ready, !s_ready, "input taken right after a config write")
    `FHD_ASSERT_SAME(a_body_not_empty, phase_reg == fhd_pkg::PH_BODY, (meta_left_reg != '0) || (payload_left_reg != '0), "body phase with no bytes left")
    `FHD_ASSERT_SAME(a_pos_header_only, phase_reg != fhd_pkg::PH_HEADER, pos_reg == '0, "header position nonzero outside header phase")
    `FHD_ASSERT_SAME(a_body_after_header, (phase_reg == fhd_pkg::PH_BODY) && ($past(phase_reg) != fhd_pkg::PH_BODY), $past(res_valid) && ($past(res.kind) == fhd_pkg::KIND_HEADER), "body entered without a header record")
    `FHD_ASSERT_NEXT(a_error_sticky, phase_reg == fhd_pkg::PH_ERROR, phase_reg == fhd_pkg::PH_ERROR, "error phase left without reset")

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the frame header deframer: byte streams of
// well-formed frames under changing header rules, random idle on both
// channels, and one rejected header at the end that must lock the parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    // indexes past the last register, writes there must change nothing
    localparam logic [fhd_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [fhd_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    // one header as it travels on the wire, first byte in the top bits
    typedef struct packed {
        logic [31:0] magic;
        logic [15:0] version;
        logic [15:0] msg_type;
        logic [31:0] flags;
        logic [31:0] meta_len;
        logic [63:0] pay_len;
        logic [63:0] stream;
    } frame_head_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_kind;
    logic [7:0]  m_byte_value;
    logic [2:0]  m_error_code;
    logic [15:0] m_msg_type;
    logic [31:0] m_frame_flags;
    logic [31:0] m_metadata_len;
    logic [63:0] m_payload_len;
    logic [63:0] m_stream_ident;
    logic        m_last;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [fhd_pkg::CFG_IDX_W-1:0] cfg_index = fhd_pkg::CFG_MAGIC;
    logic [63:0] cfg_data = 64'd0;

    frame_header_deframer dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_byte_value   (m_byte_value),
        .m_error_code   (m_error_code),
        .m_msg_type     (m_msg_type),
        .m_frame_flags  (m_frame_flags),
        .m_metadata_len (m_metadata_len),
        .m_payload_len  (m_payload_len),
        .m_stream_ident (m_stream_ident),
        .m_last         (m_last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // shadow of the header rules and of the parser state
    // ------------------------------------------------------------------

    // header rules as they stand after reset
    fhd_pkg::cfg_t rules = {32'h5244_4654, 16'd1, 64'hFFFF_FFFF_FFFF_FFFF, 32'd65536,
                            64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF};

    logic [1:0]  parse_phase = fhd_pkg::PH_HEADER;
    int          head_pos = 0;
    logic [31:0] hdr_magic = '0;
    logic [15:0] hdr_version = '0;
    logic [15:0] hdr_type = '0;
    logic [31:0] hdr_flags = '0;
    logic [63:0] hdr_stream = '0;
    logic [31:0] meta_remaining = '0;
    logic [63:0] payload_remaining = '0;

    // records and body bytes still owed by the block, oldest first
    fhd_pkg::result_t pending_records[$];

    int  mismatches = 0;
    int  results_checked = 0;
    int  items_sent = 0;
    int  frames_sent = 0;
    int  dropped_bytes = 0;
    int  final_code = -1;
    // no idling on either side while set
    bit  calm = 1'b0;

    // header rule check in priority order, -1 when the header is good
    function automatic int header_fault();
        logic [64:0] total;
        if (hdr_magic != rules.magic_word) return int'(fhd_pkg::ERR_MAGIC);
        if (hdr_version != rules.expected_version) return int'(fhd_pkg::ERR_VERSION);
        if (hdr_type >= 16'd64 || !rules.known_type_mask[hdr_type[5:0]])
            return int'(fhd_pkg::ERR_TYPE);
        if (meta_remaining > rules.max_metadata_len) return int'(fhd_pkg::ERR_META_BIG);
        if (payload_remaining > rules.max_payload_len) return int'(fhd_pkg::ERR_PAY_BIG);
        // one carry bit above 64 catches the wrapped sum
        total = 65'(fhd_pkg::HEADER_BYTES) + 65'(payload_remaining) + 65'(meta_remaining);
        if (total[64]) return int'(fhd_pkg::ERR_OVERFLOW);
        if (total[63:0] > rules.max_frame_len) return int'(fhd_pkg::ERR_FRAME_BIG);
        // totals with the top bit set are refused even when the limit allows
        if (total[63]) return int'(fhd_pkg::ERR_OVERFLOW);
        return -1;
    endfunction

    // advance the shadow parser by one byte, returns 1 when a result is owed
    function automatic bit deframe_byte(input logic [7:0] b, output fhd_pkg::result_t rec);
        int fault;
        rec = '0;
        if (parse_phase == fhd_pkg::PH_HEADER) begin
            if (head_pos < 4) hdr_magic = {hdr_magic[23:0], b};
            else if (head_pos < 6) hdr_version = {hdr_version[7:0], b};
            else if (head_pos < 8) hdr_type = {hdr_type[7:0], b};
            else if (head_pos < 12) hdr_flags = {hdr_flags[23:0], b};
            else if (head_pos < 16) meta_remaining = {meta_remaining[23:0], b};
            else if (head_pos < 24) payload_remaining = {payload_remaining[55:0], b};
            else hdr_stream = {hdr_stream[55:0], b};
            if (head_pos < fhd_pkg::HEADER_BYTES - 1) begin
                head_pos++;
                return 1'b0;
            end
            head_pos = 0;
            fault = header_fault();
            if (fault >= 0) begin
                // sticky: nothing more comes out until reset
                parse_phase = fhd_pkg::PH_ERROR;
                rec.kind = fhd_pkg::KIND_ERROR;
                rec.error_code = 3'(fault);
                rec.last = 1'b1;
                return 1'b1;
            end
            rec.kind = fhd_pkg::KIND_HEADER;
            rec.msg_type = hdr_type;
            rec.frame_flags = hdr_flags;
            rec.metadata_len = meta_remaining;
            rec.payload_len = payload_remaining;
            rec.stream_ident = hdr_stream;
            // an empty body closes the frame on the header record itself
            if (meta_remaining == 0 && payload_remaining == 0) rec.last = 1'b1;
            else parse_phase = fhd_pkg::PH_BODY;
            return 1'b1;
        end
        if (parse_phase == fhd_pkg::PH_BODY) begin
            rec.byte_value = b;
            if (meta_remaining != 0) begin
                rec.kind = fhd_pkg::KIND_META;
                meta_remaining--;
            end else begin
                rec.kind = fhd_pkg::KIND_PAYLOAD;
                if (payload_remaining != 0) payload_remaining--;
            end
            if (meta_remaining == 0 && payload_remaining == 0) begin
                rec.last = 1'b1;
                parse_phase = fhd_pkg::PH_HEADER;
                head_pos = 0;
            end
            return 1'b1;
        end
        // error phase and the unused phase drop everything
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [63:0] seen,
                                   input logic [63:0] want);
        $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, seen, want);
        mismatches++;
    endtask

    // receiver drops m_ready at random, about 8 percent of the time, unless calm
    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(0, 99) >= 8);
    end

    // every result transaction is matched against the oldest owed record
    always @(posedge aclk) begin : check_results
        fhd_pkg::result_t seen;
        fhd_pkg::result_t want;
        if (aresetn && m_valid && m_ready) begin
            seen = {m_kind, m_byte_value, m_error_code, m_msg_type, m_frame_flags,
                    m_metadata_len, m_payload_len, m_stream_ident, m_last};
            if (pending_records.size() == 0) begin
                report_mismatch("unexpected result kind", 64'(seen.kind), 64'd0);
            end else begin
                want = pending_records.pop_front();
                if (seen.kind !== want.kind)
                    report_mismatch("kind", 64'(seen.kind), 64'(want.kind));
                if (seen.byte_value !== want.byte_value)
                    report_mismatch("byte_value", 64'(seen.byte_value), 64'(want.byte_value));
                if (seen.error_code !== want.error_code)
                    report_mismatch("error_code", 64'(seen.error_code), 64'(want.error_code));
                if (seen.msg_type !== want.msg_type)
                    report_mismatch("msg_type", 64'(seen.msg_type), 64'(want.msg_type));
                if (seen.frame_flags !== want.frame_flags)
                    report_mismatch("frame_flags", 64'(seen.frame_flags),
                                    64'(want.frame_flags));
                if (seen.metadata_len !== want.metadata_len)
                    report_mismatch("metadata_len", 64'(seen.metadata_len),
                                    64'(want.metadata_len));
                if (seen.payload_len !== want.payload_len)
                    report_mismatch("payload_len", seen.payload_len, want.payload_len);
                if (seen.stream_ident !== want.stream_ident)
                    report_mismatch("stream_ident", seen.stream_ident, want.stream_ident);
                if (seen.last !== want.last)
                    report_mismatch("last", 64'(seen.last), 64'(want.last));
                results_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus side
    // ------------------------------------------------------------------

    // one byte transaction on the input channel, with random idle first
    task automatic push_byte(input logic [7:0] b);
        fhd_pkg::result_t rec;
        while (!calm && $urandom_range(0, 99) < 8) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (deframe_byte(b, rec)) pending_records.push_back(rec);
        items_sent++;
    endtask

    // stop sending and wait for every owed result, then settle a while
    task automatic wait_drained(input int settle);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_records.size() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    // one register write transaction; cfg_valid is lowered by the caller
    task automatic write_reg(input logic [fhd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            fhd_pkg::CFG_MAGIC:     rules.magic_word = val[31:0];
            fhd_pkg::CFG_VERSION:   rules.expected_version = val[15:0];
            fhd_pkg::CFG_TYPE_MASK: rules.known_type_mask = val;
            fhd_pkg::CFG_MAX_META:  rules.max_metadata_len = val[31:0];
            fhd_pkg::CFG_MAX_PAY:   rules.max_payload_len = val;
            fhd_pkg::CFG_MAX_FRAME: rules.max_frame_len = val;
            default: ;
        endcase
    endtask

    // load a full rule set while the parser sits between frames;
    // narrow registers get junk above their width, which must be masked
    task automatic set_rules(input fhd_pkg::cfg_t c, input bit poke_spare);
        wait_drained(4);
        if (poke_spare) begin
            write_reg(CFG_SPARE_A, {$urandom, $urandom});
            write_reg(CFG_SPARE_B, {$urandom, $urandom});
        end
        write_reg(fhd_pkg::CFG_MAGIC, {$urandom, c.magic_word});
        write_reg(fhd_pkg::CFG_VERSION, {$urandom, 16'($urandom), c.expected_version});
        write_reg(fhd_pkg::CFG_TYPE_MASK, c.known_type_mask);
        write_reg(fhd_pkg::CFG_MAX_META, {$urandom, c.max_metadata_len});
        write_reg(fhd_pkg::CFG_MAX_PAY, c.max_payload_len);
        write_reg(fhd_pkg::CFG_MAX_FRAME, c.max_frame_len);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_header(input frame_head_t h);
        logic [255:0] image;
        image = h;
        for (int i = 0; i < fhd_pkg::HEADER_BYTES; i++) push_byte(image[255 - 8 * i -: 8]);
    endtask

    // header plus its body of random bytes; lengths must be small here
    task automatic send_frame(input frame_head_t h, input bit stall_mid);
        int body;
        send_header(h);
        // hold the body back until the header record has come out
        if (stall_mid) wait_drained(0);
        body = int'(h.meta_len) + int'(h.pay_len);
        repeat (body) push_byte(8'($urandom));
        frames_sent++;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // frames of every body shape under the rules left by reset
    task automatic test_default_frames();
        frame_head_t h;
        // empty body: last on the header record
        h = {32'h5244_4654, 16'd1, 16'd0, 32'd0, 32'd0, 64'd0, 64'd0};
        send_frame(h, 1'b0);
        // metadata and payload, widest type index and all-ones fields
        h = {32'h5244_4654, 16'd1, 16'd63, 32'hFFFF_FFFF, 32'd2, 64'd3,
             64'hFFFF_FFFF_FFFF_FFFF};
        send_frame(h, 1'b0);
        // metadata only, with the sender held until the header is out
        h = {32'h5244_4654, 16'd1, 16'd17, $urandom, 32'd3, 64'd0, {$urandom, $urandom}};
        send_frame(h, 1'b1);
        // payload only
        h = {32'h5244_4654, 16'd1, 16'd40, $urandom, 32'd0, 64'd2, {$urandom, $urandom}};
        send_frame(h, 1'b0);
    endtask

    // register extremes and frames that sit exactly on every limit
    task automatic test_config_extremes();
        fhd_pkg::cfg_t c;
        frame_head_t h;
        // tightest rules that still pass an empty frame of type 63
        c = {32'd0, 16'd0, 64'h8000_0000_0000_0000, 32'd0, 64'd0,
             64'(fhd_pkg::HEADER_BYTES)};
        set_rules(c, 1'b1);
        h = {32'd0, 16'd0, 16'd63, $urandom, 32'd0, 64'd0, {$urandom, $urandom}};
        send_frame(h, 1'b0);
        // all-ones identity, only type 0 known, lengths equal to their limits
        c = {32'hFFFF_FFFF, 16'hFFFF, 64'd1, 32'd5, 64'd7, 64'(fhd_pkg::HEADER_BYTES + 12)};
        set_rules(c, 1'b0);
        h = {32'hFFFF_FFFF, 16'hFFFF, 16'd0, 32'd0, 32'd5, 64'd7, 64'd0};
        send_frame(h, 1'b0);
        // widest limits
        c = {$urandom, 16'($urandom), 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF,
             64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF};
        set_rules(c, 1'b0);
        h = {c.magic_word, c.expected_version, 16'd31, $urandom, 32'd2, 64'd1,
             {$urandom, $urandom}};
        send_frame(h, 1'b0);
    endtask

    // well-formed frames with random content, rules changed every few frames
    task automatic test_random_frames();
        fhd_pkg::cfg_t c;
        frame_head_t h;
        int start;
        int nframe;
        int cap_meta;
        int cap_pay;
        int t;
        start = items_sent;
        nframe = 0;
        while (items_sent - start < 370) begin
            if (nframe % 5 == 0) begin
                case ($urandom_range(0, 3))
                    0: c.magic_word = '0;
                    1: c.magic_word = '1;
                    default: c.magic_word = $urandom;
                endcase
                c.expected_version = 16'($urandom);
                if ($urandom_range(0, 3) == 0) c.known_type_mask = '1;
                else c.known_type_mask = ({$urandom, $urandom} & {$urandom, $urandom})
                                         | (64'd1 << $urandom_range(0, 63));
                c.max_metadata_len = ($urandom_range(0, 1) != 0) ?
                                     32'($urandom_range(0, 8)) : 32'($urandom);
                c.max_payload_len = ($urandom_range(0, 1) != 0) ?
                                    64'($urandom_range(0, 16)) : {$urandom, $urandom};
                cap_meta = (c.max_metadata_len < 6) ? int'(c.max_metadata_len) : 6;
                cap_pay = (c.max_payload_len < 12) ? int'(c.max_payload_len) : 12;
                // frame limit: open, exactly the largest frame used, or above it
                case ($urandom_range(0, 2))
                    0: c.max_frame_len = '1;
                    1: c.max_frame_len = 64'(fhd_pkg::HEADER_BYTES + cap_meta + cap_pay);
                    default: c.max_frame_len = 64'(fhd_pkg::HEADER_BYTES + cap_meta + cap_pay)
                                               + 64'($urandom);
                endcase
                set_rules(c, 1'b0);
            end
            // a stretch of frames with both sides running flat out
            calm = (nframe >= 2 && nframe < 8);
            t = $urandom_range(0, 63);
            while (!rules.known_type_mask[t]) t = $urandom_range(0, 63);
            h.magic = rules.magic_word;
            h.version = rules.expected_version;
            h.msg_type = 16'(t);
            h.flags = $urandom;
            h.meta_len = 32'($urandom_range(0, cap_meta));
            h.pay_len = 64'($urandom_range(0, cap_pay));
            h.stream = {$urandom, $urandom};
            send_frame(h, $urandom_range(0, 11) == 0);
            nframe++;
        end
        calm = 1'b0;
    endtask

    // one rejected header, picked at random since the lock lasts until reset;
    // later checks are often broken too so the priority order shows
    task automatic test_sticky_error();
        fhd_pkg::cfg_t c;
        frame_head_t h;
        logic [63:0] total;
        int t;
        final_code = $urandom_range(0, 6);
        t = $urandom_range(0, 63);
        c = {$urandom, 16'($urandom), {$urandom, $urandom} | (64'd1 << t), 32'hFFFF_FFFF,
             64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF};
        h = {c.magic_word, c.expected_version, 16'(t), $urandom,
             32'($urandom_range(0, 1000)), 64'($urandom_range(0, 1000)), {$urandom, $urandom}};
        case (3'(final_code))
            fhd_pkg::ERR_MAGIC: begin
                h.magic ^= 32'd1 << $urandom_range(0, 31);
                if ($urandom_range(0, 1) != 0) h.version = ~h.version;
            end
            fhd_pkg::ERR_VERSION: begin
                h.version ^= 16'd1 << $urandom_range(0, 15);
                if ($urandom_range(0, 1) != 0) h.msg_type = 16'($urandom_range(64, 65535));
            end
            fhd_pkg::ERR_TYPE: begin
                if ($urandom_range(0, 1) != 0) h.msg_type = 16'($urandom_range(64, 65535));
                else c.known_type_mask[t] = 1'b0;
                if ($urandom_range(0, 1) != 0) c.max_metadata_len = '0;
            end
            fhd_pkg::ERR_META_BIG: begin
                c.max_metadata_len = $urandom_range(0, 4096);
                h.meta_len = $urandom_range(c.max_metadata_len + 1, 32'hFFFF_FFFF);
                if ($urandom_range(0, 1) != 0) c.max_payload_len = '0;
            end
            fhd_pkg::ERR_PAY_BIG: begin
                c.max_payload_len = {$urandom, $urandom} >> 1;
                h.pay_len = c.max_payload_len + 64'd1 + 64'($urandom_range(0, 50));
                if ($urandom_range(0, 1) != 0) c.max_frame_len = '0;
            end
            fhd_pkg::ERR_OVERFLOW: begin
                if ($urandom_range(0, 1) != 0) begin
                    // the 64-bit sum wraps
                    h.pay_len = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 40));
                    h.meta_len = $urandom_range(41, 1000);
                    if ($urandom_range(0, 1) != 0) c.max_frame_len = 64'($urandom);
                end else begin
                    // no wrap, but the total reaches the top bit
                    h.meta_len = $urandom_range(0, 1000);
                    h.pay_len = 64'h8000_0000_0000_0000 - 64'(fhd_pkg::HEADER_BYTES)
                                - 64'(h.meta_len) + 64'($urandom_range(0, 3));
                end
            end
            default: begin
                if ($urandom_range(0, 1) != 0) begin
                    total = 64'(fhd_pkg::HEADER_BYTES) + 64'(h.meta_len) + h.pay_len;
                    c.max_frame_len = 64'($urandom_range(0, int'(total) - 1));
                end else begin
                    // frame limit wins over the top-bit rule
                    h.pay_len = 64'h8000_0000_0000_0000 + 64'($urandom);
                    c.max_frame_len = {1'b0, 31'($urandom), $urandom};
                end
            end
        endcase
        set_rules(c, 1'b0);
        send_header(h);
        // everything after the error is swallowed, a clean header included
        h = {rules.magic_word, rules.expected_version, 16'd0, 32'd0, 32'd0, 64'd0, 64'd0};
        send_header(h);
        repeat (16) push_byte(8'($urandom));
        dropped_bytes = fhd_pkg::HEADER_BYTES + 16;
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_default_frames();
        test_config_extremes();
        test_random_frames();
        test_sticky_error();
        wait_drained(8);
        $display("covered %0d frames in %0d byte transactions, %0d results checked",
                 frames_sent, items_sent, results_checked);
        $display("stream locked by error code %0d, then %0d bytes dropped",
                 final_code, dropped_bytes);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // hard stop well past the slowest legal run
    initial begin
        #2_000_000;
        $display("timeout with %0d results outstanding", pending_records.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
